// File: sv/upa_pkg.sv
// Shared types, codes and saturation helpers for the uncertainty propagation ALU.
// Used by the front end, the queue, the back end and the top level.
`default_nettype none
package upa_pkg;

  localparam int DW = 32;
  localparam int EW = 31;
  localparam int FB = 16;

  localparam logic [47:0] POS_LIMIT = 48'h0000_7FFF_FFFF;
  localparam logic [47:0] NEG_LIMIT = 48'h0000_8000_0000;
  localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [EW-1:0] ERR_MAX = {EW{1'b1}};

  typedef enum logic [2:0] {
    OP_ADD        = 3'd0,
    OP_SUB        = 3'd1,
    OP_DIV        = 3'd2,
    OP_ADD_SCALAR = 3'd3,
    OP_SUB_SCALAR = 3'd4,
    OP_MUL_SCALAR = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    K_SUM,
    K_SHIFT,
    K_DIV,
    K_DIVZ,
    K_MUL,
    K_PASS
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIVZ = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef struct packed {
    kind_t           kind;
    logic            neg;
    logic [DW-1:0]   am;
    logic [DW-1:0]   bm;
    logic [EW-1:0]   ea;
    logic [EW-1:0]   eb;
    logic [DW:0]     sum;
    logic [DW-1:0]   a_raw;
  } entry_t;

  typedef struct packed {
    logic          sat;
    logic [DW-1:0] val;
  } vpack_t;

  function automatic vpack_t pack_value(input logic neg, input logic [47:0] mag);
    vpack_t r;
    r.sat = 1'b0;
    r.val = neg ? (~mag[DW-1:0] + {{(DW-1){1'b0}}, 1'b1}) : mag[DW-1:0];
    if (!neg && mag > POS_LIMIT) begin
      r.sat = 1'b1;
      r.val = VAL_MAX;
    end else if (neg && mag > NEG_LIMIT) begin
      r.sat = 1'b1;
      r.val = VAL_MIN;
    end
    return r;
  endfunction

  function automatic vpack_t sat_sum(input logic [DW:0] s);
    vpack_t r;
    r.sat = s[DW] ^ s[DW-1];
    r.val = r.sat ? (s[DW] ? VAL_MIN : VAL_MAX) : s[DW-1:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: sv/upa_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Generic; carries a sideband word alongside each transaction. No package use.
`default_nettype none
module upa_div #(
  parameter int NW = 64,
  parameter int DW = 32,
  parameter int QW = 32,
  parameter int SW = 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic               out_valid,
  output logic [QW-1:0]      quo_out,
  output logic               ovf_out,
  output logic [SW-1:0]      side_out
);

  logic [DW-1:0] hi_ext;
  logic          vld  [QW+1];
  logic [DW-1:0] rem  [QW];
  logic [QW-1:0] low  [QW];
  logic [DW-1:0] dvs  [QW];
  logic [QW-1:0] quo  [QW+1];
  logic          ovf  [QW+1];
  logic [SW-1:0] side [QW+1];

  assign hi_ext = DW'(num[NW-1:QW]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= hi_ext;
      low[0]  <= num[QW-1:0];
      dvs[0]  <= den;
      quo[0]  <= '0;
      ovf[0]  <= hi_ext >= den;
      side[0] <= side_in;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    assign trial = {rem[i], low[i][QW-1]};
    assign ge    = trial >= {1'b0, dvs[i]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[i+1]  <= {quo[i][QW-2:0], ge};
        ovf[i+1]  <= ovf[i];
        side[i+1] <= side[i];
      end
    end

    if (i < QW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[i+1] <= ge ? DW'(trial - {1'b0, dvs[i]}) : trial[DW-1:0];
          low[i+1] <= {low[i][QW-2:0], 1'b0};
          dvs[i+1] <= dvs[i];
        end
      end
    end
  end

  assign out_valid = vld[QW];
  assign quo_out   = quo[QW];
  assign ovf_out   = ovf[QW];
  assign side_out  = side[QW];

endmodule
`default_nettype wire

// File: sv/upa_isqrt.sv
// Pipelined integer square root, one root bit per stage (floor result).
// Generic; carries a sideband word alongside each transaction. No package use.
`default_nettype none
module upa_isqrt #(
  parameter int XW = 64,
  parameter int SW = 1
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            en,
  input  wire logic            in_valid,
  input  wire logic [XW-1:0]   x,
  input  wire logic [SW-1:0]   side_in,
  output logic                 out_valid,
  output logic [XW/2-1:0]      root_out,
  output logic [SW-1:0]        side_out
);

  localparam int OW = XW / 2;

  logic            vld  [OW+1];
  logic [OW+1:0]   rem  [OW];
  logic [XW-1:0]   xs   [OW];
  logic [OW-1:0]   root [OW+1];
  logic [SW-1:0]   side [OW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= '0;
      xs[0]   <= x;
      root[0] <= '0;
      side[0] <= side_in;
    end
  end

  for (genvar k = 0; k < OW; k++) begin : g_step
    logic [OW+3:0] cur;
    logic [OW+3:0] trial;
    logic          ge;

    assign cur   = {rem[k], xs[k][XW-1:XW-2]};
    assign trial = {2'b00, root[k], 2'b01};
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root[k+1] <= {root[k][OW-2:0], ge};
        side[k+1] <= side[k];
      end
    end

    if (k < OW-1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? (OW+2)'(cur - trial) : cur[OW+1:0];
          xs[k+1]  <= {xs[k][XW-3:0], 2'b00};
        end
      end
    end
  end

  assign out_valid = vld[OW];
  assign root_out  = root[OW];
  assign side_out  = side[OW];

endmodule
`default_nettype wire

// File: sv/upa_fifo.sv
// Short queue between the front end and the back end.
// Holds upa_pkg::entry_t transactions; depends on upa_pkg.
`default_nettype none
module upa_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push_valid,
  input  wire upa_pkg::entry_t push_data,
  output logic                 full,
  output logic                 pop_valid,
  output upa_pkg::entry_t      pop_data,
  input  wire logic            pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  upa_pkg::entry_t mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full      = count == FULL_COUNT;
  assign pop_valid = count != '0;
  assign pop_data  = mem[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/upa_front.sv
// Front end: accepts input transactions, splits signs and magnitudes, classifies.
// Produces upa_pkg::entry_t for the queue; depends on upa_pkg.
`default_nettype none
module upa_front (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] a_value,
  input  wire logic [30:0] a_error,
  input  wire logic [31:0] b_value,
  input  wire logic [30:0] b_error,
  output logic             push_valid,
  output upa_pkg::entry_t  push_data,
  input  wire logic        push_full
);

  logic            held;
  upa_pkg::entry_t slot;
  upa_pkg::entry_t cls;
  logic            a_neg;
  logic            b_neg;
  logic [31:0]     am;
  logic [31:0]     bm;
  logic [32:0]     s_add;
  logic [32:0]     s_sub;

  assign item_stall = held && push_full;
  assign push_valid = held;
  assign push_data  = slot;

  always_comb begin
    a_neg = a_value[31];
    b_neg = b_value[31];
    am    = a_neg ? (~a_value + 32'd1) : a_value;
    bm    = b_neg ? (~b_value + 32'd1) : b_value;
    s_add = {a_value[31], a_value} + {b_value[31], b_value};
    s_sub = {a_value[31], a_value} - {b_value[31], b_value};
    cls.neg   = a_neg ^ b_neg;
    cls.am    = am;
    cls.bm    = bm;
    cls.ea    = a_error;
    cls.eb    = b_error;
    cls.sum   = s_add;
    cls.a_raw = a_value;
    unique case (upa_pkg::op_t'(operation))
      upa_pkg::OP_ADD:        cls.kind = upa_pkg::K_SUM;
      upa_pkg::OP_SUB: begin
        cls.kind = upa_pkg::K_SUM;
        cls.sum  = s_sub;
      end
      upa_pkg::OP_DIV:        cls.kind = (bm == '0) ? upa_pkg::K_DIVZ : upa_pkg::K_DIV;
      upa_pkg::OP_ADD_SCALAR: cls.kind = upa_pkg::K_SHIFT;
      upa_pkg::OP_SUB_SCALAR: begin
        cls.kind = upa_pkg::K_SHIFT;
        cls.sum  = s_sub;
      end
      upa_pkg::OP_MUL_SCALAR: cls.kind = upa_pkg::K_MUL;
      default:                cls.kind = upa_pkg::K_PASS;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!item_stall) begin
      held <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      slot <= cls;
    end
  end

endmodule
`default_nettype wire

// File: sv/upa_back.sv
// Back end: multipliers, pipelined dividers, square root and result packing.
// Depends on upa_pkg, upa_div and upa_isqrt; the whole pipeline holds on output stall.
`default_nettype none
module upa_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            pop_valid,
  input  wire upa_pkg::entry_t pop_data,
  output logic                 pop,
  output logic                 result_valid,
  input  wire logic            result_stall,
  output logic [31:0]          result_value,
  output logic [30:0]          result_error,
  output logic [1:0]           status
);

  typedef struct packed {
    upa_pkg::kind_t kind;
    logic           neg;
    logic [31:0]    am;
    logic [31:0]    bm;
    logic [30:0]    ea;
    logic [30:0]    eb;
    logic [32:0]    sum;
    logic [31:0]    a_raw;
    logic [63:0]    p_mv;
    logic [62:0]    p_me;
  } qside_t;

  typedef struct packed {
    upa_pkg::kind_t kind;
    logic           neg;
    logic [32:0]    sum;
    logic           q_ovf;
  } t2side_t;

  typedef struct packed {
    logic [31:0] a_raw;
    logic [63:0] p_mv;
    logic [30:0] eb;
  } vside_t;

  typedef struct packed {
    logic [30:0] ea;
    logic [62:0] p_me;
  } t1side_t;

  typedef struct packed {
    logic [31:0] rv;
    logic        vsat;
    logic        use_sqrt;
    logic [30:0] edir;
    logic        esat;
    logic        divz;
  } rside_t;

  logic            adv;
  logic            m_valid;
  upa_pkg::entry_t m_e;
  logic [62:0]     p_q;
  logic [63:0]     p_mv;
  logic [62:0]     p_me;
  qside_t          qs_in;
  qside_t          qs_out;
  logic            q_valid;
  logic [47:0]     q_quo;
  logic            q_ovf;
  t2side_t         t2s_in;
  t2side_t         t2s_out;
  vside_t          vs_in;
  vside_t          vs_out;
  t1side_t         t1s_in;
  t1side_t         t1s_out;
  logic            t2_valid;
  logic            v_valid;
  logic            t1_valid;
  logic [31:0]     t2_quo;
  logic [31:0]     v_quo;
  logic [31:0]     t1_quo;
  logic            t2_ovf;
  logic            v_ovf;
  logic            t1_ovf;
  logic            d_valid;
  logic            t1_big;
  logic            t2_big;
  logic [30:0]     sx;
  logic [30:0]     sy;
  upa_pkg::vpack_t vp;
  logic [46:0]     emag;
  rside_t          s_next;
  logic            s_valid;
  logic [61:0]     sq_x;
  logic [61:0]     sq_y;
  rside_t          s_r;
  logic [63:0]     rad;
  logic            r_valid;
  logic [31:0]     root;
  rside_t          r_side;
  logic            root_sat;

  assign adv = !result_valid || !result_stall;
  assign pop = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_e  <= pop_data;
      p_q  <= {31'b0, pop_data.am} * {32'b0, pop_data.eb};
      p_mv <= {32'b0, pop_data.am} * {32'b0, pop_data.bm};
      p_me <= {32'b0, pop_data.ea} * {31'b0, pop_data.bm};
    end
  end

  always_comb begin
    qs_in.kind  = m_e.kind;
    qs_in.neg   = m_e.neg;
    qs_in.am    = m_e.am;
    qs_in.bm    = m_e.bm;
    qs_in.ea    = m_e.ea;
    qs_in.eb    = m_e.eb;
    qs_in.sum   = m_e.sum;
    qs_in.a_raw = m_e.a_raw;
    qs_in.p_mv  = p_mv;
    qs_in.p_me  = p_me;
  end

  upa_div #(.NW(63), .DW(32), .QW(48), .SW($bits(qside_t))) u_qdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (m_valid),
    .num       (p_q),
    .den       (m_e.bm),
    .side_in   (qs_in),
    .out_valid (q_valid),
    .quo_out   (q_quo),
    .ovf_out   (q_ovf),
    .side_out  (qs_out)
  );

  always_comb begin
    t2s_in.kind  = qs_out.kind;
    t2s_in.neg   = qs_out.neg;
    t2s_in.sum   = qs_out.sum;
    t2s_in.q_ovf = q_ovf;
    vs_in.a_raw  = qs_out.a_raw;
    vs_in.p_mv   = qs_out.p_mv;
    vs_in.eb     = qs_out.eb;
    t1s_in.ea    = qs_out.ea;
    t1s_in.p_me  = qs_out.p_me;
  end

  upa_div #(.NW(64), .DW(32), .QW(32), .SW($bits(t2side_t))) u_t2div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (q_valid),
    .num       ({q_quo, {upa_pkg::FB{1'b0}}}),
    .den       (qs_out.bm),
    .side_in   (t2s_in),
    .out_valid (t2_valid),
    .quo_out   (t2_quo),
    .ovf_out   (t2_ovf),
    .side_out  (t2s_out)
  );

  upa_div #(.NW(48), .DW(32), .QW(32), .SW($bits(vside_t))) u_vdiv (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (q_valid),
    .num       ({qs_out.am, {upa_pkg::FB{1'b0}}}),
    .den       (qs_out.bm),
    .side_in   (vs_in),
    .out_valid (v_valid),
    .quo_out   (v_quo),
    .ovf_out   (v_ovf),
    .side_out  (vs_out)
  );

  upa_div #(.NW(47), .DW(32), .QW(32), .SW($bits(t1side_t))) u_t1div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (q_valid),
    .num       ({qs_out.ea, {upa_pkg::FB{1'b0}}}),
    .den       (qs_out.bm),
    .side_in   (t1s_in),
    .out_valid (t1_valid),
    .quo_out   (t1_quo),
    .ovf_out   (t1_ovf),
    .side_out  (t1s_out)
  );

  always_comb begin
    d_valid = t2_valid && v_valid && t1_valid;
    t1_big  = t1_ovf || t1_quo[31];
    t2_big  = t2s_out.q_ovf || t2_ovf || t2_quo[31];
    sx      = (t2s_out.kind == upa_pkg::K_DIV) ? t1_quo[30:0] : t1s_out.ea;
    sy      = (t2s_out.kind == upa_pkg::K_DIV) ? t2_quo[30:0] : vs_out.eb;
    emag    = t1s_out.p_me[62:16];
    vp      = upa_pkg::sat_sum(t2s_out.sum);
    s_next.rv       = vp.val;
    s_next.vsat     = vp.sat;
    s_next.use_sqrt = 1'b0;
    s_next.edir     = t1s_out.ea;
    s_next.esat     = 1'b0;
    s_next.divz     = 1'b0;
    unique case (t2s_out.kind)
      upa_pkg::K_SUM: begin
        s_next.use_sqrt = 1'b1;
      end
      upa_pkg::K_SHIFT: begin
        s_next.use_sqrt = 1'b0;
      end
      upa_pkg::K_DIV: begin
        vp = upa_pkg::pack_value(t2s_out.neg, v_ovf ? '1 : {16'b0, v_quo});
        s_next.rv       = vp.val;
        s_next.vsat     = vp.sat;
        s_next.use_sqrt = !(t1_big || t2_big);
        s_next.edir     = upa_pkg::ERR_MAX;
        s_next.esat     = t1_big || t2_big;
      end
      upa_pkg::K_DIVZ: begin
        s_next.rv   = '0;
        s_next.vsat = 1'b0;
        s_next.edir = '0;
        s_next.divz = 1'b1;
      end
      upa_pkg::K_MUL: begin
        vp = upa_pkg::pack_value(t2s_out.neg, vs_out.p_mv[63:16]);
        s_next.rv   = vp.val;
        s_next.vsat = vp.sat;
        s_next.esat = |emag[46:31];
        s_next.edir = s_next.esat ? upa_pkg::ERR_MAX : emag[30:0];
      end
      default: begin
        s_next.rv   = vs_out.a_raw;
        s_next.vsat = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (adv) begin
      s_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_x <= {31'b0, sx} * {31'b0, sx};
      sq_y <= {31'b0, sy} * {31'b0, sy};
      s_r  <= s_next;
    end
  end

  assign rad = {2'b00, sq_x} + {2'b00, sq_y};

  upa_isqrt #(.XW(64), .SW($bits(rside_t))) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (s_valid),
    .x         (rad),
    .side_in   (s_r),
    .out_valid (r_valid),
    .root_out  (root),
    .side_out  (r_side)
  );

  assign root_sat = r_side.use_sqrt && root[31];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= r_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result_value <= r_side.rv;
      if (r_side.use_sqrt) begin
        result_error <= root[31] ? upa_pkg::ERR_MAX : root[30:0];
      end else begin
        result_error <= r_side.edir;
      end
      if (r_side.divz) begin
        status <= upa_pkg::ST_DIVZ;
      end else if (r_side.vsat || r_side.esat || root_sat) begin
        status <= upa_pkg::ST_SAT;
      end else begin
        status <= upa_pkg::ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

// File: sv/uncertainty_propagation_alu_unit.sv
// Path: front register, queue, back input register, the 48-stage and 32-stage divider
// pipelines, the squaring register, the 32-stage square root and the result register.
// Throughput: one transaction per cycle; the front register and queue take up to
// five transactions while a result waits, and the back end holds as a whole on stall.
// Reset: synchronous, active high; clears all valid bits and queue pointers.
`default_nettype none
module uncertainty_propagation_alu_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] a_value,
  input  wire logic [30:0] a_error,
  input  wire logic [31:0] b_value,
  input  wire logic [30:0] b_error,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [31:0]      result_value,
  output logic [30:0]      result_error,
  output logic [1:0]       status
);

  logic            push_valid;
  upa_pkg::entry_t push_data;
  logic            push_full;
  logic            pop_valid;
  upa_pkg::entry_t pop_data;
  logic            pop;

  upa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .operation  (operation),
    .a_value    (a_value),
    .a_error    (a_error),
    .b_value    (b_value),
    .b_error    (b_error),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_full  (push_full)
  );

  upa_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (push_full),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop        (pop)
  );

  upa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .pop_valid    (pop_valid),
    .pop_data     (pop_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .result_error (result_error),
    .status       (status)
  );

  a_divz_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == upa_pkg::ST_DIVZ |-> result_value == '0 && result_error == '0)
    else $error("divide by zero result not cleared");

  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire
